FILE: rtl/bam_pkg.sv
// ----------------------------------------------------------------------------
// bam_pkg: shared types and constants of the bitmap allocation map
// Sizes of the map, field widths, request and status codes, and the
// payload structs of both channels.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int NUM_BITS   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int NW_W       = WADDR_W + 1;
  localparam int BPOS_W     = $clog2(WORD_BITS);

  localparam int MODE_W     = 3;
  localparam int IDX_W      = 10;
  localparam int FILL_W     = 32;
  localparam int SIZE_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int SIZE_RESET = 1024;

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FILL  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ALREADY  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  bit_index;
    logic [FILL_W-1:0] fill_word;
  } bam_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bit_was_set;
    logic [IDX_W-1:0]    found_index;
    logic                map_empty;
    logic                map_full;
  } bam_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } bam_state_t;

endpackage

FILE: rtl/bam_ram.sv
// ----------------------------------------------------------------------------
// bam_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bitmap_allocation_map.sv
// ----------------------------------------------------------------------------
// bitmap_allocation_map: bit allocation map held in a word memory
// Sets, clears, tests and searches bits, zeroes or fills the whole map,
// and reports with every result whether the valid bits are all clear or
// all set.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Direction
//   -------   ---------------------------------   ---------------------------
//   input     in_valid, in_stall, in_data         requests into the block
//   result    out_valid, out_stall, out_data      one result per request
//   config    cfg_we, cfg_wdata                   size_in_use register write
//
// The single read port of the word memory shapes the work on a request:
// every request sweeps all valid words once, one word per cycle, to build
// the empty and full flags, and set, clear, test and search are folded into
// that same sweep; a size of zero sweeps no word. Reset is synchronous and
// active low; it clears the map at once through one valid bit per word and
// loads the size register with 1024. A stalled result waits in the output
// register while the block already takes and works on the next request.
// ----------------------------------------------------------------------------
module bitmap_allocation_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bam_pkg::bam_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bam_pkg::bam_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [bam_pkg::SIZE_W-1:0] cfg_wdata
);

  import bam_pkg::*;

  // Lowest set bit of a word, given as its position.
  function automatic logic [BPOS_W-1:0] low_pos(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] one_hot;
    logic [BPOS_W-1:0]    pos;
    one_hot = x & (~x + WORD_BITS'(1));
    pos     = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos = pos | (one_hot[j] ? BPOS_W'(j) : '0);
    end
    return pos;
  endfunction

  // Control and configuration state.
  bam_state_t            state_r, state_nxt;
  logic [SIZE_W-1:0]     size_r;
  logic [NUM_WORDS-1:0]  wvld_r;      // word has been written since reset/zero/fill
  logic [WORD_BITS-1:0]  bg_r;        // value of a word that was never written

  // Request held for the sweep.
  logic [MODE_W-1:0]     mode_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  in_range_r;
  logic [NW_W-1:0]       nw_r;        // number of words holding valid bits
  logic [BPOS_W-1:0]     rem_r;       // valid bits in the last word, zero if full

  // Sweep pipeline.
  logic [NW_W-1:0]       rd_w_r;
  logic                  p_vld_r;
  logic [WADDR_W-1:0]    p_w_r;
  logic                  p_bg_r;

  // Result accumulators.
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  was_r, was_nxt;
  logic [IDX_W-1:0]      found_r, found_nxt;
  logic                  hit_r, hit_nxt;
  logic                  empty_r, empty_nxt;
  logic                  full_r, full_nxt;

  // Output register.
  logic                  out_valid_r;
  bam_out_t              out_data_r;

  // Datapath.
  logic                  in_acc, out_free, load_out, rd_en, issuing, sweep_done;
  logic [SIZE_W-1:0]     vsize;
  logic [SIZE_W-1:0]     nw_full;
  logic [WORD_BITS-1:0]  ram_rdata, d_old, d_new, d_mod, vmask, lomask, cand, bmask;
  logic [WADDR_W-1:0]    tw;
  logic [BPOS_W-1:0]     bp;
  logic                  is_tgt, cur_bit, bit_op, chg, ram_we, last_w;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Size above the map is treated as the whole map.
  assign vsize   = (size_r > SIZE_W'(NUM_BITS)) ? SIZE_W'(NUM_BITS) : size_r;
  assign nw_full = (vsize + SIZE_W'(WORD_BITS - 1)) >> BPOS_W;

  assign issuing    = rd_w_r < nw_r;
  assign sweep_done = !issuing && !p_vld_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, then outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SWEEP: rd_en    = issuing;
      ST_FIN:   load_out = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Word processing: the word read last cycle is modified, checked against
  // the valid bits and searched. Only the word that holds the addressed bit
  // is ever written back, and it is read only once per request, so the
  // sweep needs no forwarding.
  // ---------------------------------------------------------------------------
  assign tw      = WADDR_W'(idx_r >> BPOS_W);
  assign bp      = idx_r[BPOS_W-1:0];
  assign d_old   = p_bg_r ? bg_r : ram_rdata;
  assign is_tgt  = (p_w_r == tw);
  assign cur_bit = d_old[bp];
  assign bmask   = WORD_BITS'(1) << bp;
  assign last_w  = (NW_W'(p_w_r) + NW_W'(1)) == nw_r;
  assign vmask   = (last_w && (rem_r != '0)) ? ~({WORD_BITS{1'b1}} << rem_r)
                                             : {WORD_BITS{1'b1}};
  assign lomask  = (p_w_r > tw)  ? {WORD_BITS{1'b1}} :
                   (is_tgt)      ? ({WORD_BITS{1'b1}} << bp) : '0;
  assign cand    = ~d_old & vmask & lomask;

  // Bit requests only act on the target word and only when in range.
  assign bit_op = p_vld_r && in_range_r && is_tgt && (mode_r <= MODE_FIND);

  always_comb begin
    d_mod = d_old;
    chg   = 1'b0;
    case (mode_r)
      MODE_SET: begin
        d_mod = d_old | bmask;
        chg   = !cur_bit;
      end
      MODE_CLEAR: begin
        d_mod = d_old & ~bmask;
        chg   = cur_bit;
      end
      default: begin
        d_mod = d_old;
        chg   = 1'b0;
      end
    endcase
  end

  assign ram_we = bit_op && chg;
  assign d_new  = ram_we ? d_mod : d_old;

  always_comb begin
    status_nxt = status_r;
    was_nxt    = was_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    empty_nxt  = empty_r;
    full_nxt   = full_r;
    if (p_vld_r) begin
      empty_nxt = empty_r && ((d_new & vmask) == '0);
      full_nxt  = full_r && ((~d_new & vmask) == '0);
      if (bit_op) begin
        was_nxt = cur_bit;
        if (!chg && (mode_r == MODE_SET || mode_r == MODE_CLEAR)) begin
          status_nxt = STAT_ALREADY;
        end
      end
      if (mode_r == MODE_FIND && in_range_r && !hit_r && cand != '0) begin
        hit_nxt    = 1'b1;
        status_nxt = STAT_OK;
        found_nxt  = IDX_W'({p_w_r, low_pos(cand)});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word memory.
  // ---------------------------------------------------------------------------
  bam_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_w_r),
    .wdata (d_new),
    .re    (rd_en),
    .raddr (rd_w_r[WADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_W'(SIZE_RESET);
      wvld_r      <= '0;
      bg_r        <= '0;
      rd_w_r      <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end

      // Zero and fill take effect at the transfer: every word falls back to
      // the background value until it is written again.
      if (in_acc && (in_data.mode == MODE_ZERO || in_data.mode == MODE_FILL)) begin
        wvld_r <= '0;
        bg_r   <= (in_data.mode == MODE_FILL) ? WORD_BITS'(in_data.fill_word) : '0;
      end else if (ram_we) begin
        wvld_r[p_w_r] <= 1'b1;
      end

      if (in_acc) begin
        rd_w_r <= '0;
      end else if (rd_en) begin
        rd_w_r <= rd_w_r + NW_W'(1);
      end
      p_vld_r <= rd_en;

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_w_r  <= rd_w_r[WADDR_W-1:0];
      p_bg_r <= !wvld_r[rd_w_r[WADDR_W-1:0]];
    end
    if (in_acc) begin
      mode_r     <= in_data.mode;
      idx_r      <= in_data.bit_index;
      in_range_r <= {1'b0, in_data.bit_index} < vsize;
      nw_r       <= nw_full[NW_W-1:0];
      rem_r      <= vsize[BPOS_W-1:0];
      was_r      <= 1'b0;
      found_r    <= '0;
      hit_r      <= 1'b0;
      empty_r    <= 1'b1;
      full_r     <= 1'b1;
      if (in_data.mode <= MODE_FIND) begin
        if ({1'b0, in_data.bit_index} >= vsize) begin
          status_r <= STAT_RANGE;
        end else if (in_data.mode == MODE_FIND) begin
          status_r <= STAT_NOTFOUND;
        end else begin
          status_r <= STAT_OK;
        end
      end else begin
        status_r <= STAT_OK;
      end
    end else begin
      status_r <= status_nxt;
      was_r    <= was_nxt;
      found_r  <= found_nxt;
      hit_r    <= hit_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
    end
    if (load_out) begin
      out_data_r.status      <= status_r;
      out_data_r.bit_was_set <= was_r;
      out_data_r.found_index <= found_r;
      out_data_r.map_empty   <= empty_r;
      out_data_r.map_full    <= full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_we_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_SWEEP)
    else $error("word written outside a sweep");

  a_one_write : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !ram_we)
    else $error("more than one word written for a request");

  a_read_bound : assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_w_r < nw_r)
    else $error("sweep read beyond the valid words");

  a_accept_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SWEEP && rd_w_r == '0 && !p_vld_r)
    else $error("transfer did not start a fresh sweep");

  a_notfound_zero : assert property (@(posedge clk) disable iff (!rst_n)
    load_out && status_r != STAT_OK |-> found_r == '0)
    else $error("found index reported with a failing status");

endmodule

FILE: test/tb_bitmap_allocation_map.sv
// ----------------------------------------------------------------------------
// tb_bitmap_allocation_map: self-checking testbench of the bit allocation map
// A short table of directed requests runs first. Random requests over a range
// of map sizes follow, with random gaps on the request side and random stalls
// on the result side. Every result transfer is checked field by field against
// a prediction kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_bitmap_allocation_map;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  // The block decodes these two request codes as no operation.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // The directed table holds 27 requests and 3 size writes.
  localparam int PLAN_LEN     = 30;
  // This covers one full sweep of the map plus the output register.
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 130;

  // One row of the directed table. A row is either a write of the size
  // register or a request. A request row may carry an expected result
  // that is typed in by hand. When it does not, the predictor supplies it.
  typedef struct packed {
    logic              is_cfg;
    logic [SIZE_W-1:0] cfg_size;
    bam_in_t           req;
    logic              typed;
    bam_out_t          want;
  } plan_row_t;

  // Every input of the block starts at a known value. Reset is held low
  // from time zero.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  bam_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bam_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // This is the testbench's own copy of the map and of the size register.
  // The expected results wait in transfer order.
  logic [NUM_BITS-1:0] map_bits;
  logic [SIZE_W-1:0]   map_size;
  bam_out_t            pending_results[$];
  int                  fail_count = 0;

  // While calm is set, neither side idles. This gives stretches of
  // back-to-back transfers.
  bit                  calm       = 1'b0;
  int                  stall_left = 0;

  bitmap_allocation_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The clock has a 2 ns period. Its first rising edge comes at 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle lengths are mostly zero or short. A few reach past the longest
  // sweep of the block, so that gaps land on every cycle of its work.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // This function runs one request against the local map and returns the
  // result that the block has to produce. Sizes above the map length count
  // as the full map. With a size of zero no bit is valid, so the map counts
  // as both empty and full.
  function automatic bam_out_t apply_to_map(bam_in_t req);
    bam_out_t res;
    int       lim;
    int       b;
    logic     hit;
    logic     any_set;
    logic     any_clear;
    res = '0;
    lim = (map_size > NUM_BITS) ? NUM_BITS : int'(map_size);
    case (req.mode) inside
      MODE_SET, MODE_CLEAR, MODE_TEST, MODE_FIND: begin
        if (int'(req.bit_index) >= lim) begin
          // An index out of range changes nothing and reports nothing else.
          res.status = STAT_RANGE;
        end else begin
          res.bit_was_set = map_bits[req.bit_index];
          if (req.mode == MODE_SET) begin
            if (res.bit_was_set) begin
              res.status = STAT_ALREADY;
            end else begin
              map_bits[req.bit_index] = 1'b1;
            end
          end else if (req.mode == MODE_CLEAR) begin
            if (!res.bit_was_set) begin
              res.status = STAT_ALREADY;
            end else begin
              map_bits[req.bit_index] = 1'b0;
            end
          end else if (req.mode == MODE_FIND) begin
            // The search runs from the start offset to the last valid bit.
            res.status = STAT_NOTFOUND;
            hit = 1'b0;
            for (b = int'(req.bit_index); b < lim && !hit; b++) begin
              if (!map_bits[b]) begin
                hit             = 1'b1;
                res.status      = STAT_OK;
                res.found_index = IDX_W'(b);
              end
            end
          end
        end
      end
      MODE_ZERO: begin
        map_bits = '0;
      end
      MODE_FILL: begin
        // A fill writes every word, including words past the valid size.
        for (b = 0; b < NUM_WORDS; b++) begin
          map_bits[b*WORD_BITS +: WORD_BITS] = WORD_BITS'(req.fill_word);
        end
      end
      default: begin
      end
    endcase
    any_set   = 1'b0;
    any_clear = 1'b0;
    for (b = 0; b < lim; b++) begin
      if (map_bits[b]) begin
        any_set = 1'b1;
      end else begin
        any_clear = 1'b1;
      end
    end
    res.map_empty = !any_set;
    res.map_full  = !any_clear;
    return res;
  endfunction

  // These helpers build the rows of the directed table.
  function automatic plan_row_t req_row(logic [MODE_W-1:0] mode, int idx,
                                        logic [FILL_W-1:0] fill);
    plan_row_t row;
    row                   = '0;
    row.req.mode          = mode;
    row.req.bit_index     = IDX_W'(idx);
    row.req.fill_word     = fill;
    return row;
  endfunction

  function automatic plan_row_t req_chk(logic [MODE_W-1:0] mode, int idx,
                                        logic [FILL_W-1:0] fill,
                                        logic [STATUS_W-1:0] status,
                                        logic was, int found,
                                        logic empty_f, logic full_f);
    plan_row_t row;
    row                  = req_row(mode, idx, fill);
    row.typed            = 1'b1;
    row.want.status      = status;
    row.want.bit_was_set = was;
    row.want.found_index = IDX_W'(found);
    row.want.map_empty   = empty_f;
    row.want.map_full    = full_f;
    return row;
  endfunction

  function automatic plan_row_t size_row(int size);
    plan_row_t row;
    row          = '0;
    row.is_cfg   = 1'b1;
    row.cfg_size = SIZE_W'(size);
    return row;
  endfunction

  // This function builds one random request for the current size.
  // Set and clear are weighted so that the map both fills and drains.
  // A fill with all ones, or with all ones but one bit, makes full maps
  // and failed searches common. Most indexes fall inside the valid range.
  // The rest land on the last valid bit, on the first invalid bit, or
  // anywhere in the field.
  function automatic bam_in_t random_request();
    bam_in_t req;
    int      lim;
    int      r;
    lim           = (map_size > NUM_BITS) ? NUM_BITS : int'(map_size);
    req.fill_word = $urandom();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      req.mode = MODE_SET;
    end else if (r < 50) begin
      req.mode = MODE_CLEAR;
    end else if (r < 62) begin
      req.mode = MODE_TEST;
    end else if (r < 82) begin
      req.mode = MODE_FIND;
    end else if (r < 86) begin
      req.mode = MODE_ZERO;
    end else if (r < 95) begin
      req.mode = MODE_FILL;
    end else if (r < 97) begin
      req.mode = MODE_SPARE_LO;
    end else begin
      req.mode = MODE_SPARE_HI;
    end
    r = $urandom_range(0, 19);
    if (lim == 0 || r == 0) begin
      req.bit_index = IDX_W'($urandom_range(0, NUM_BITS - 1));
    end else if (r == 1) begin
      req.bit_index = IDX_W'(lim - 1);
    end else if (r == 2 && lim < NUM_BITS) begin
      req.bit_index = IDX_W'(lim);
    end else begin
      req.bit_index = IDX_W'($urandom_range(0, lim - 1));
    end
    if (req.mode == MODE_FILL) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        req.fill_word = '1;
      end else if (r < 6) begin
        req.fill_word = ~(32'd1 << $urandom_range(0, FILL_W - 1));
      end
    end
    return req;
  endfunction

  // This task offers one request and holds it steady until its transfer.
  // The expectation is queued at the transfer edge. That is the point where
  // the block commits to the request and the local map moves with it.
  task automatic send_request(input bam_in_t req, input logic typed,
                              input bam_out_t want);
    bam_out_t pred;
    int       gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_to_map(req);
    pending_results.push_back(typed ? want : pred);
  endtask

  // This task drops valid and waits until every expected result has come
  // back. Each request yields exactly one result, so the block is idle then.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // A size write is a single-cycle strobe. It is only issued while idle.
  task automatic write_size(input logic [SIZE_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we    <= 1'b0;
    map_size   = size;
  endtask

  // The result side stalls in random bursts. The stall changes only at the
  // falling edge, so a result held by a stall sees it steady at the next
  // rising edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  // This function compares one field, reports a mismatch, and tells the
  // caller whether the field matched.
  function automatic bit field_ok(string name, logic [31:0] want_v,
                                  logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Each result transfer is matched against the oldest expectation. The
  // bitwise AND evaluates every field, so each mismatching field is reported.
  always @(posedge clk) begin
    bam_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected: %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (!(field_ok("status", want.status, out_data.status) &
              field_ok("bit_was_set", want.bit_was_set, out_data.bit_was_set) &
              field_ok("found_index", want.found_index, out_data.found_index) &
              field_ok("map_empty", want.map_empty, out_data.map_empty) &
              field_ok("map_full", want.map_full, out_data.map_full))) begin
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan [PLAN_LEN];
    int        phase_size [8];
    int        p;
    int        k;
    int        n;
    int        sz;

    map_bits   = '0;
    map_size   = SIZE_W'(SIZE_RESET);
    phase_size = '{5, 0, 2047, 1, 32, 33, 1024, 1025};

    // The directed table starts from the reset state: all bits are clear
    // and the size is the full map. It walks the edges of the index range,
    // the already-in-state cases, searches that succeed and fail, and
    // fills. It also covers a size of zero, a size of one, and a size
    // above the map length.
    plan = '{
      req_chk(MODE_TEST,   0,    32'h0,        STAT_OK,       1'b0, 0,   1'b1, 1'b0),
      req_chk(MODE_TEST,   1023, 32'h0,        STAT_OK,       1'b0, 0,   1'b1, 1'b0),
      req_chk(MODE_CLEAR,  5,    32'h0,        STAT_ALREADY,  1'b0, 0,   1'b1, 1'b0),
      req_chk(MODE_SET,    0,    32'h0,        STAT_OK,       1'b0, 0,   1'b0, 1'b0),
      req_chk(MODE_SET,    0,    32'h0,        STAT_ALREADY,  1'b1, 0,   1'b0, 1'b0),
      req_chk(MODE_SET,    1023, 32'h0,        STAT_OK,       1'b0, 0,   1'b0, 1'b0),
      req_chk(MODE_FIND,   0,    32'h0,        STAT_OK,       1'b1, 1,   1'b0, 1'b0),
      req_chk(MODE_FIND,   1023, 32'h0,        STAT_NOTFOUND, 1'b1, 0,   1'b0, 1'b0),
      req_chk(MODE_FILL,   0,    32'hFFFFFFFF, STAT_OK,       1'b0, 0,   1'b0, 1'b1),
      req_chk(MODE_CLEAR,  512,  32'h0,        STAT_OK,       1'b1, 0,   1'b0, 1'b0),
      req_chk(MODE_FIND,   100,  32'h0,        STAT_OK,       1'b1, 512, 1'b0, 1'b0),
      req_chk(MODE_SET,    512,  32'h0,        STAT_OK,       1'b0, 0,   1'b0, 1'b1),
      req_chk(MODE_FIND,   0,    32'h0,        STAT_NOTFOUND, 1'b1, 0,   1'b0, 1'b1),
      req_row(MODE_FILL,   0,    32'hA5A55A5A),
      req_row(MODE_TEST,   3,    32'h0),
      req_row(MODE_FIND,   0,    32'h0),
      req_row(MODE_SPARE_LO, 1023, 32'hFFFFFFFF),
      req_row(MODE_SPARE_HI, 0,  32'h0),
      req_chk(MODE_ZERO,   0,    32'h0,        STAT_OK,       1'b0, 0,   1'b1, 1'b0),
      size_row(0),
      req_chk(MODE_TEST,   0,    32'h0,        STAT_RANGE,    1'b0, 0,   1'b1, 1'b1),
      req_chk(MODE_FIND,   1023, 32'h0,        STAT_RANGE,    1'b0, 0,   1'b1, 1'b1),
      req_chk(MODE_FILL,   0,    32'hFFFFFFFF, STAT_OK,       1'b0, 0,   1'b1, 1'b1),
      size_row(1),
      req_chk(MODE_CLEAR,  0,    32'h0,        STAT_OK,       1'b1, 0,   1'b1, 1'b0),
      req_chk(MODE_SET,    1,    32'h0,        STAT_RANGE,    1'b0, 0,   1'b1, 1'b0),
      req_chk(MODE_FIND,   0,    32'h0,        STAT_OK,       1'b0, 0,   1'b1, 1'b0),
      size_row(2047),
      req_chk(MODE_TEST,   1023, 32'h0,        STAT_OK,       1'b1, 0,   1'b0, 1'b0),
      req_chk(MODE_ZERO,   0,    32'h0,        STAT_OK,       1'b0, 0,   1'b1, 1'b0)
    };

    // Reset is held low at the start and then released for good.
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < PLAN_LEN; p++) begin
      if (plan[p].is_cfg) begin
        wait_idle();
        write_size(plan[p].cfg_size);
      end else begin
        send_request(plan[p].req, plan[p].typed, plan[p].want);
      end
    end

    // In the random part, each phase first lets the block drain and then
    // writes a new size. The first phases use fixed sizes: small and word-
    // aligned sizes, zero, the full map, and sizes above the map length.
    // Later phases pick sizes at random. The map content carries over
    // from phase to phase, so each size starts from whatever the last left.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 8) begin
        sz = phase_size[p];
      end else if ($urandom_range(0, 1) == 0) begin
        sz = $urandom_range(1, 64);
      end else begin
        sz = $urandom_range(65, 2047);
      end
      wait_idle();
      write_size(SIZE_W'(sz));
      n = (sz == 0) ? 40 : PHASE_ITEMS;
      for (k = 0; k < n; k++) begin
        if (k % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        send_request(random_request(), 1'b0, '0);
      end
    end

    // Every result must come back. After that, a quiet stretch catches
    // any stray result transfer.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_bitmap_allocation_map: PASS");
    end else begin
      $display("tb_bitmap_allocation_map: FAIL");
    end
    $finish;
  end

  // A hung handshake ends the run here. The limit is several times the
  // slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_bitmap_allocation_map: FAIL");
    $finish;
  end

endmodule
